// File: hw/rtl/esckd_pkg.sv
// ----------------------------------------------------------------------------
// esckd_pkg
// shared constants for the escape sequence key decoder: line capacity,
// byte codes, key command codes, parser phases and sequencer states
// ----------------------------------------------------------------------------
package esckd_pkg;

    localparam int LINE_CAPACITY = 20;
    localparam int CNT_W         = $clog2(LINE_CAPACITY + 1);
    localparam int ADDR_W        = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

    localparam int KC_W  = 4;
    localparam int LEN_W = 5;

    // byte codes
    localparam logic [7:0] B_BS    = 8'd8;
    localparam logic [7:0] B_LF    = 8'd10;
    localparam logic [7:0] B_CR    = 8'd13;
    localparam logic [7:0] B_ESC   = 8'd27;
    localparam logic [7:0] B_SPACE = 8'h20;
    localparam logic [7:0] B_LBR   = 8'd91;
    localparam logic [7:0] B_BQ    = 8'h60;
    localparam logic [7:0] B_TILDE = 8'h7E;
    localparam logic [7:0] B_DEL   = 8'd127;
    localparam logic [7:0] B_UP    = 8'h41;
    localparam logic [7:0] B_DOWN  = 8'h42;
    localparam logic [7:0] B_RIGHT = 8'h43;
    localparam logic [7:0] B_LEFT  = 8'h44;
    localparam logic [7:0] B_ONE   = 8'h31;
    localparam logic [7:0] B_TWO   = 8'h32;
    localparam logic [7:0] B_FIVE  = 8'h35;

    // key command codes
    localparam logic [KC_W-1:0] KC_NONE       = 4'd0;
    localparam logic [KC_W-1:0] KC_RIGHT      = 4'd1;
    localparam logic [KC_W-1:0] KC_LEFT       = 4'd2;
    localparam logic [KC_W-1:0] KC_UP         = 4'd3;
    localparam logic [KC_W-1:0] KC_DOWN       = 4'd4;
    localparam logic [KC_W-1:0] KC_MOVE_LEFT  = 4'd5;
    localparam logic [KC_W-1:0] KC_ENTER      = 4'd6;
    localparam logic [KC_W-1:0] KC_MOVE_RIGHT = 4'd7;
    localparam logic [KC_W-1:0] KC_TYPED      = 4'd8;
    localparam logic [KC_W-1:0] KC_QUIT       = 4'd9;

    // input command codes
    localparam logic CMD_KEY   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // parser phases
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_ESC   = 2'd1;
    localparam logic [1:0] PH_CSI   = 2'd2;
    localparam logic [1:0] PH_TILDE = 2'd3;

    // sequencer states
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

endpackage

// File: hw/rtl/esckd_ram.sv
// ----------------------------------------------------------------------------
// esckd_ram
// generic simple dual-port ram: one write port, one read port, registered read
// ----------------------------------------------------------------------------
module esckd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 20
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/escape_sequence_key_decoder.sv
// ----------------------------------------------------------------------------
// escape_sequence_key_decoder
// decodes keyboard bytes into key commands and keeps a bounded typed line,
// read out of a line ram one character per word after line feed or carriage return
// ----------------------------------------------------------------------------
// output: a result word is registered from its accepted input word
// throughput: one input word per cycle unless stalled; a typed line holds
//   the input for 1 + line_length output words, a ram read per character
// reset: synchronous active low; parser idle, line empty, no output word
// ----------------------------------------------------------------------------
module escape_sequence_key_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_command,
    input  logic [7:0] i_key_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [3:0] o_key_command,
    output logic [4:0] o_line_length,
    output logic [7:0] o_line_char,
    output logic       o_char_valid,
    output logic       o_last
);

    logic                                  r_state, n_state;
    logic [1:0]                            r_phase, n_phase;
    logic [esckd_pkg::CNT_W-1:0]           r_count, n_count;
    logic [esckd_pkg::ADDR_W-1:0]          r_idx, n_idx;
    logic                                  r_out_valid;
    logic [esckd_pkg::KC_W-1:0]            r_kc;
    logic [esckd_pkg::LEN_W-1:0]           r_len;
    logic [7:0]                            r_char;
    logic                                  r_cvalid;
    logic                                  r_last;

    logic                                  out_free;
    logic                                  in_acc;
    logic                                  do_plain;
    logic                                  wr_en;
    logic [esckd_pkg::KC_W-1:0]            kc;
    logic [7:0]                            rd_data;
    logic                                  rd_last;
    logic [esckd_pkg::CNT_W-1:0]           idx_ext;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign in_acc     = i_in_valid && (r_state == esckd_pkg::ST_IDLE) && out_free;
    assign o_in_stall = !((r_state == esckd_pkg::ST_IDLE) && out_free);

    assign idx_ext = esckd_pkg::CNT_W'(r_idx);
    assign rd_last = (idx_ext + esckd_pkg::CNT_W'(1)) == r_count;

    // key decode and line edit
    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        kc       = esckd_pkg::KC_NONE;
        do_plain = 1'b0;
        wr_en    = 1'b0;
        if (i_command == esckd_pkg::CMD_CLEAR) begin
            n_count = '0;
        end else if (i_key_byte == esckd_pkg::B_BQ) begin
            kc = esckd_pkg::KC_QUIT;
        end else begin
            case (r_phase)
                esckd_pkg::PH_IDLE: begin
                    if (i_key_byte == esckd_pkg::B_ESC) begin
                        n_phase = esckd_pkg::PH_ESC;
                    end else begin
                        do_plain = 1'b1;
                    end
                end
                esckd_pkg::PH_ESC: begin
                    if (i_key_byte == esckd_pkg::B_LBR) begin
                        n_phase = esckd_pkg::PH_CSI;
                    end else begin
                        n_phase  = esckd_pkg::PH_IDLE;
                        do_plain = 1'b1;
                    end
                end
                esckd_pkg::PH_CSI: begin
                    n_phase = esckd_pkg::PH_IDLE;
                    case (i_key_byte)
                        esckd_pkg::B_UP:    kc = esckd_pkg::KC_UP;
                        esckd_pkg::B_DOWN:  kc = esckd_pkg::KC_DOWN;
                        esckd_pkg::B_RIGHT: kc = esckd_pkg::KC_RIGHT;
                        esckd_pkg::B_LEFT:  kc = esckd_pkg::KC_LEFT;
                        esckd_pkg::B_ONE: begin
                            kc      = esckd_pkg::KC_ENTER;
                            n_phase = esckd_pkg::PH_TILDE;
                        end
                        esckd_pkg::B_TWO: begin
                            kc      = esckd_pkg::KC_MOVE_LEFT;
                            n_phase = esckd_pkg::PH_TILDE;
                        end
                        esckd_pkg::B_FIVE: begin
                            kc      = esckd_pkg::KC_MOVE_RIGHT;
                            n_phase = esckd_pkg::PH_TILDE;
                        end
                        default: do_plain = 1'b1;
                    endcase
                end
                default: begin
                    n_phase = esckd_pkg::PH_IDLE;
                    if (i_key_byte != esckd_pkg::B_TILDE) begin
                        do_plain = 1'b1;
                    end
                end
            endcase
            if (do_plain) begin
                if ((i_key_byte == esckd_pkg::B_BS) || (i_key_byte == esckd_pkg::B_DEL)) begin
                    if (r_count != '0) begin
                        n_count = r_count - esckd_pkg::CNT_W'(1);
                    end
                end else if (i_key_byte inside {[8'h41:8'h5A], [8'h61:8'h7A],
                                                [8'h30:8'h39], esckd_pkg::B_SPACE}) begin
                    if (r_count < esckd_pkg::CNT_W'(esckd_pkg::LINE_CAPACITY)) begin
                        wr_en   = 1'b1;
                        n_count = r_count + esckd_pkg::CNT_W'(1);
                    end
                end else if ((i_key_byte == esckd_pkg::B_LF) ||
                             (i_key_byte == esckd_pkg::B_CR)) begin
                    kc = esckd_pkg::KC_TYPED;
                end
            end
        end
    end

    // sequencer; ram address is the next index so read data matches r_idx
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        if (r_state == esckd_pkg::ST_IDLE) begin
            n_idx = '0;
            if (in_acc && (kc == esckd_pkg::KC_TYPED) && (r_count != '0)) begin
                n_state = esckd_pkg::ST_READ;
            end
        end else if (out_free) begin
            if (rd_last) begin
                n_state = esckd_pkg::ST_IDLE;
                n_idx   = '0;
            end else begin
                n_idx = r_idx + esckd_pkg::ADDR_W'(1);
            end
        end
    end

    esckd_ram #(
        .WIDTH (8),
        .DEPTH (esckd_pkg::LINE_CAPACITY)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && wr_en),
        .i_waddr (r_count[esckd_pkg::ADDR_W-1:0]),
        .i_wdata (i_key_byte),
        .i_raddr (n_idx),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= esckd_pkg::ST_IDLE;
            r_phase     <= esckd_pkg::PH_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (in_acc) begin
                r_phase     <= n_phase;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (r_state == esckd_pkg::ST_READ) begin
                if (out_free) begin
                    r_out_valid <= 1'b1;
                end
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kc     <= kc;
            r_len    <= esckd_pkg::LEN_W'(n_count);
            r_char   <= '0;
            r_cvalid <= 1'b0;
            r_last   <= !((kc == esckd_pkg::KC_TYPED) && (r_count != '0));
        end else if ((r_state == esckd_pkg::ST_READ) && out_free) begin
            r_kc     <= esckd_pkg::KC_NONE;
            r_len    <= esckd_pkg::LEN_W'(r_count);
            r_char   <= rd_data;
            r_cvalid <= 1'b1;
            r_last   <= rd_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_key_command = r_kc;
    assign o_line_length = r_len;
    assign o_line_char   = r_char;
    assign o_char_valid  = r_cvalid;
    assign o_last        = r_last;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= esckd_pkg::CNT_W'(esckd_pkg::LINE_CAPACITY))
        else $error("line count above capacity");

    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == esckd_pkg::ST_READ) |-> (r_count != '0))
        else $error("read-out with empty line");

    a_read_word_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == esckd_pkg::ST_READ) |-> (r_out_valid && !r_last))
        else $error("read-out without a pending non-final word");

    a_char_cmd_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_cvalid) |-> (r_kc == esckd_pkg::KC_NONE))
        else $error("character word with a key command");

    a_read_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == esckd_pkg::ST_READ) && out_free && rd_last) |=>
        ((r_state == esckd_pkg::ST_IDLE) && r_last && r_cvalid))
        else $error("read-out did not finish on the last character");
`endif

endmodule
